// ===== rtl/core/dfs_pkg.sv =====
// Package for the delimited field splitter: payload structs, parse modes,
// result kinds, byte constants and configuration register indexes.
// No dependencies.
package dfs_pkg;

  localparam int LEN_W   = 13;
  localparam int CFG_W   = 64;
  localparam int CFG_IDX_W = 3;

  // Largest usable field buffer; larger buffer_size values in the low LEN_W bits of a write are clamped.
  localparam logic [LEN_W-1:0] MAX_FIELD = 13'd4096;

  localparam logic [7:0] BYTE_NUL   = 8'h00;
  localparam logic [7:0] BYTE_NL    = 8'h0A;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_QUOTE = 8'h22;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_LOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_MID_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_MID_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HIGH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE  = 3'd4;

  typedef enum logic [2:0] {
    MODE_START  = 3'd0,
    MODE_PLAIN  = 3'd1,
    MODE_QUOTED = 3'd2,
    MODE_TAIL   = 3'd3,
    MODE_SPACES = 3'd4,
    MODE_HALT   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_OVF  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       out_byte;
    logic [LEN_W-1:0] field_length;
    logic             ended_by_eof;
  } result_t;

  typedef struct packed {
    mode_t            mode;
    logic [LEN_W-1:0] length;
    logic             has_result;
    result_t          result;
  } step_t;

endpackage

// ===== rtl/core/dfs_if.sv =====
// Valid/ready channel interfaces for the input byte stream and the results.
// Depends on dfs_pkg.
interface dfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface dfs_out_if;
  logic                        valid;
  logic                        ready;
  dfs_pkg::kind_t              kind;
  logic [7:0]                  out_byte;
  logic [dfs_pkg::LEN_W-1:0]   field_length;
  logic                        ended_by_eof;

  modport source (output valid, output kind, output out_byte, output field_length,
                  output ended_by_eof, input ready);
  modport sink   (input valid, input kind, input out_byte, input field_length,
                  input ended_by_eof, output ready);
endinterface

// ===== rtl/core/delimited_field_splitter_core.sv =====
// Top level of the delimited field splitter: input register, parse state,
// configuration registers and result register. Depends on dfs_pkg, dfs_if
// and dfs_step.
//
//   channel  dir  payload                                        beat when
//   in_ch    in   in_byte, end_of_stream                         valid && ready
//   out_ch   out  kind, out_byte, field_length, ended_by_eof     valid && ready
//   cfg      in   cfg_index, cfg_wdata                           cfg_we
//
// One byte is taken per cycle while the result register is not stalled. A
// result passes through the input register, then the result register, before
// it is offered. The rate is set by the update of the parse mode and field
// length registers.
// Synchronous active-low reset clears the parse state, both valid flags and
// the configuration to tab-delimited with a 4096-byte buffer.
// A stalled result holds in the result register while one more byte waits in
// the input register; only then does in_ch drop ready.
module delimited_field_splitter_core (
  input  logic                           clk,
  input  logic                           rst_n,
  dfs_in_if.sink                         in_ch,
  dfs_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [dfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dfs_pkg::CFG_W-1:0]      cfg_wdata
);
  import dfs_pkg::*;

  // Configuration. The buffer size is stored already clamped to 1..MAX_FIELD.
  logic [255:0]     delim_map_r;
  logic [LEN_W-1:0] eff_size_r;
  logic [LEN_W-1:0] size_nxt;

  // Parse state.
  mode_t            mode_r;
  logic [LEN_W-1:0] length_r;

  // Input register and result register.
  logic     in_valid_r;
  in_item_t in_item_r;
  logic     out_valid_r;
  result_t  res_r;

  logic     in_beat;
  logic     advance;
  step_t    step;

  always_comb begin
    size_nxt = cfg_wdata[LEN_W-1:0];
    if (size_nxt == '0) begin
      size_nxt = LEN_W'(1);
    end else if (size_nxt > MAX_FIELD) begin
      size_nxt = MAX_FIELD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_map_r <= 256'd512;
      eff_size_r  <= MAX_FIELD;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAP_LOW:      delim_map_r[63:0]    <= cfg_wdata;
        CFG_MAP_MID_LOW:  delim_map_r[127:64]  <= cfg_wdata;
        CFG_MAP_MID_HIGH: delim_map_r[191:128] <= cfg_wdata;
        CFG_MAP_HIGH:     delim_map_r[255:192] <= cfg_wdata;
        CFG_BUFFER_SIZE:  eff_size_r           <= size_nxt;
        default: begin
        end
      endcase
    end
  end

  // The byte in the input register is processed whenever the result
  // register is empty or is being emptied in this cycle.
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_beat     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_beat) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      in_item_r.in_byte       <= in_ch.in_byte;
      in_item_r.end_of_stream <= in_ch.end_of_stream;
    end
  end

  dfs_step u_step (
    .mode_i      (mode_r),
    .length_i    (length_r),
    .item_i      (in_item_r),
    .delim_map_i (delim_map_r),
    .eff_size_i  (eff_size_r),
    .step_o      (step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_START;
      length_r <= '0;
    end else if (advance) begin
      mode_r   <= step.mode;
      length_r <= step.length;
    end
  end

  // A byte that gives no result still frees the result register if its
  // old contents were taken in this cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step.has_result;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step.has_result) begin
      res_r <= step.result;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = res_r.kind;
  assign out_ch.out_byte     = res_r.out_byte;
  assign out_ch.field_length = res_r.field_length;
  assign out_ch.ended_by_eof = res_r.ended_by_eof;

`ifndef SYNTH
  // Once an overflow is reported the parser must be halted for good.
  a_ovf_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.kind == KIND_OVF)) |-> (mode_r == MODE_HALT))
    else $error("overflow result without halted parser");

  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_HALT) |=> (mode_r == MODE_HALT))
    else $error("parser left the halted mode");

  // Between fields no byte may be counted.
  a_start_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ((mode_r == MODE_START) || (mode_r == MODE_SPACES)) |-> (length_r == '0))
    else $error("field length not cleared between fields");

  a_eof_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.ended_by_eof) |-> (res_r.kind == KIND_END))
    else $error("end-of-stream flag on a result that is not a field end");
`endif

endmodule

// ===== rtl/core/dfs_step.sv =====
// Combinational parse step: one byte against the current mode and length.
// Depends on dfs_pkg.
module dfs_step (
  input  dfs_pkg::mode_t                mode_i,
  input  logic [dfs_pkg::LEN_W-1:0]     length_i,
  input  dfs_pkg::in_item_t             item_i,
  input  logic [255:0]                  delim_map_i,
  input  logic [dfs_pkg::LEN_W-1:0]     eff_size_i,
  output dfs_pkg::step_t                step_o
);
  import dfs_pkg::*;

  logic             eof;
  logic [7:0]       b;
  logic             is_delim;
  logic             want_end;
  logic             want_store;
  logic [LEN_W-1:0] len_base;
  logic [LEN_W-1:0] len_inc;

  assign eof      = item_i.end_of_stream;
  assign b        = item_i.in_byte;
  // NUL and newline always end an unquoted field.
  assign is_delim = (b == BYTE_NUL) || (b == BYTE_NL) || delim_map_i[b];

  always_comb begin
    want_end   = 1'b0;
    want_store = 1'b0;
    len_base   = length_i;
    step_o     = '0;
    step_o.mode   = mode_i;
    step_o.length = length_i;
    case (mode_i)
      MODE_HALT: begin
      end
      MODE_PLAIN: begin
        want_end   = eof || is_delim;
        want_store = !want_end;
      end
      MODE_QUOTED: begin
        if (eof || (b == BYTE_NL)) begin
          want_end = 1'b1;
        end else if (b == BYTE_QUOTE) begin
          step_o.mode = MODE_TAIL;
        end else begin
          want_store = 1'b1;
        end
      end
      MODE_TAIL: begin
        want_end = eof || is_delim;
      end
      default: begin
        // Field start, and the space skip once a non-space shows up.
        len_base      = '0;
        step_o.length = '0;
        if ((mode_i == MODE_SPACES) && !eof && (b == BYTE_SPACE)) begin
          step_o.mode = MODE_SPACES;
        end else if (!eof && (b == BYTE_QUOTE)) begin
          step_o.mode = MODE_QUOTED;
        end else begin
          step_o.mode = MODE_PLAIN;
          want_end    = eof || is_delim;
          want_store  = !want_end;
        end
      end
    endcase

    len_inc = len_base + LEN_W'(1);

    if (want_end) begin
      step_o.has_result          = 1'b1;
      step_o.result.kind         = KIND_END;
      step_o.result.out_byte     = eof ? BYTE_NUL : b;
      step_o.result.field_length = len_base;
      step_o.result.ended_by_eof = eof;
      step_o.length              = '0;
      step_o.mode = (!eof && (b == BYTE_SPACE)) ? MODE_SPACES : MODE_START;
    end else if (want_store) begin
      step_o.has_result      = 1'b1;
      step_o.result.out_byte = b;
      step_o.length          = len_inc;
      if (len_inc >= eff_size_i) begin
        step_o.result.kind         = KIND_OVF;
        step_o.result.field_length = eff_size_i;
        step_o.mode                = MODE_HALT;
      end else begin
        step_o.result.kind         = KIND_DATA;
        step_o.result.field_length = len_inc;
      end
    end
  end

endmodule
